### design/bop_pkg.sv
// ----------------------------------------------------------------------------
// bop_pkg
// shared widths, register indexes and constants of the binomial option pricer
// ----------------------------------------------------------------------------
package bop_pkg;

    localparam int PRICE_WIDTH       = 48;
    localparam int FACTOR_WIDTH      = 32;
    localparam int FRAC_BITS         = 30;
    localparam int STEPS_WIDTH       = 11;
    localparam int CFG_INDEX_WIDTH   = 3;
    localparam int DEFAULT_MAX_STEPS = 1024;

    typedef logic [PRICE_WIDTH-1:0]  price_t;
    typedef logic [FACTOR_WIDTH-1:0] factor_t;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UP       = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DOWN     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GROWTH   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DISCOUNT = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEPS    = 3'd4;

    // 1.0 in q2.30
    localparam factor_t ONE_Q30 = factor_t'(64'd1 << FRAC_BITS);

endpackage

### design/bop_in_if.sv
// ----------------------------------------------------------------------------
// bop_in_if
// request channel: spot, strike and option kind of one item
// ----------------------------------------------------------------------------
interface bop_in_if;

    logic              valid;
    logic              ready;
    bop_pkg::price_t   spot_price;
    bop_pkg::price_t   strike_price;
    logic              is_put;
    logic              early_exercise;

    modport source (output valid, output spot_price, output strike_price,
                    output is_put, output early_exercise, input ready);
    modport sink   (input valid, input spot_price, input strike_price,
                    input is_put, input early_exercise, output ready);

endinterface

### design/bop_out_if.sv
// ----------------------------------------------------------------------------
// bop_out_if
// result channel: option value at the lattice root and status
// ----------------------------------------------------------------------------
interface bop_out_if;

    logic              valid;
    logic              ready;
    bop_pkg::price_t   option_value;
    logic              status;

    modport source (output valid, output option_value, output status, input ready);
    modport sink   (input valid, input option_value, input status, output ready);

endinterface

### design/bop_fmul.sv
// ----------------------------------------------------------------------------
// bop_fmul
// price times q2.30 factor, rounded half up and saturated; done rises after
// the FM_LO, FM_HI and FM_SUM states that follow start
// ----------------------------------------------------------------------------
module bop_fmul
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  bop_pkg::price_t  x,
    input  bop_pkg::factor_t f,
    output logic             done,
    output bop_pkg::price_t  product
);

    localparam int PW = bop_pkg::PRICE_WIDTH;
    localparam int FW = bop_pkg::FACTOR_WIDTH;
    localparam int HW = PW - FW;
    localparam int FB = bop_pkg::FRAC_BITS;
    localparam int SW = PW + 3;

    typedef enum logic [1:0] {
        FM_IDLE,
        FM_LO,
        FM_HI,
        FM_SUM
    } fm_state_t;

    fm_state_t               state_reg;
    bop_pkg::price_t         x_reg;
    bop_pkg::factor_t        f_reg;
    logic [2*FW-1:0]         pl_reg;
    logic [HW+FW-1:0]        ph_reg;
    bop_pkg::price_t         product_reg;
    logic                    done_reg;

    logic [2*FW:0]           pl_round;
    logic [SW-1:0]           sum;

    // low partial product rounded into the q24.24 grid, high one shifted in
    assign pl_round = {1'b0, pl_reg} + (2*FW+1)'(64'd1 << (FB - 1));
    assign sum      = SW'({ph_reg, 2'b00}) + SW'(pl_round >> FB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FM_IDLE;
            x_reg       <= '0;
            f_reg       <= '0;
            pl_reg      <= '0;
            ph_reg      <= '0;
            product_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                FM_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= x;
                        f_reg     <= f;
                        state_reg <= FM_LO;
                    end
                end
                FM_LO:
                begin
                    pl_reg    <= x_reg[FW-1:0] * f_reg;
                    state_reg <= FM_HI;
                end
                FM_HI:
                begin
                    ph_reg    <= x_reg[PW-1:FW] * f_reg;
                    state_reg <= FM_SUM;
                end
                FM_SUM:
                begin
                    if (sum[SW-1:PW] != '0)
                        product_reg <= '1;
                    else
                        product_reg <= sum[PW-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= FM_IDLE;
                end
                default:
                    state_reg <= FM_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

### design/binomial_option_pricer.sv
// ----------------------------------------------------------------------------
// binomial_option_pricer
// cox-ross-rubinstein lattice pricer built round one shared multiplier
// ----------------------------------------------------------------------------
// One item (spot, strike, put flag, early-exercise flag) is priced on a
// recombining lattice of steps_in_use steps (0 acts as 1, values above
// MAX_STEPS clamp). Software loads up, down, growth and discount factors in
// q2.30; the block forms p = (g-d)/(u-d) with a bit-serial divider and
// answers status 1 with value 0 at once if p falls outside 0..1 or up
// equals down. Otherwise it builds the leaf prices, the leaf payoffs, then
// walks back level by level. Every product goes through one multiplier,
// and the sequencer waits in a wait state for each of its answers; for an
// american option backward induction also reprices each node for early
// exercise. Node prices and values live in two single-port-read memories
// of MAX_STEPS+1 entries. The request is taken only while idle; a finished
// result waits in an output register, and the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module binomial_option_pricer
#(
    parameter int MAX_STEPS = bop_pkg::DEFAULT_MAX_STEPS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bop_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [bop_pkg::FACTOR_WIDTH-1:0]     cfg_data,
    bop_in_if.sink                               request,
    bop_out_if.source                            result
);

    localparam int AW  = $clog2(MAX_STEPS + 1);
    localparam int FW  = bop_pkg::FACTOR_WIDTH;
    localparam int FB  = bop_pkg::FRAC_BITS;
    localparam int DW  = FW + FB;
    localparam int CW  = $clog2(DW);
    localparam logic [AW-1:0] N_MAX     = AW'(MAX_STEPS);
    localparam logic [CW-1:0] DIV_LAST  = CW'(DW - 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV,
        ST_F_INIT,
        ST_FU_RD,
        ST_FU_GO,
        ST_FU_WT,
        ST_FD_RD,
        ST_FD_GO,
        ST_FD_WT,
        ST_L_RD,
        ST_L_WR,
        ST_B_LD,
        ST_B_LD0,
        ST_B_RD,
        ST_B_M1,
        ST_B_W1,
        ST_B_M2,
        ST_B_W2,
        ST_B_M3,
        ST_B_W3,
        ST_B_M4,
        ST_B_W4,
        ST_B_WR,
        ST_DONE
    } state_t;

    // configuration registers
    bop_pkg::factor_t                up_reg;
    bop_pkg::factor_t                down_reg;
    bop_pkg::factor_t                growth_reg;
    bop_pkg::factor_t                disc_reg;
    logic [bop_pkg::STEPS_WIDTH-1:0] steps_reg;

    // sequencer state
    state_t            state_reg;
    logic [AW-1:0]     n_reg;
    logic [AW-1:0]     i_reg;
    logic [AW-1:0]     j_reg;
    bop_pkg::price_t   spot_reg;
    bop_pkg::price_t   strike_reg;
    logic              put_reg;
    logic              amer_reg;

    // divider
    bop_pkg::factor_t  den_reg;
    bop_pkg::factor_t  rem_reg;
    logic [DW-1:0]     divd_reg;
    bop_pkg::factor_t  quo_reg;
    logic [CW-1:0]     dcnt_reg;

    // probabilities, p_reg and qp_reg set by the divider for each priced item
    bop_pkg::factor_t  p_reg;
    bop_pkg::factor_t  qp_reg;

    // backward induction working registers
    bop_pkg::price_t   carry_reg;
    bop_pkg::price_t   vnext_reg;
    bop_pkg::price_t   phold_reg;
    bop_pkg::price_t   a_reg;
    bop_pkg::price_t   s_reg;
    bop_pkg::price_t   cont_reg;
    bop_pkg::price_t   ex_reg;

    // result
    bop_pkg::price_t   fin_val_reg;
    logic              fin_stat_reg;
    bop_pkg::price_t   out_val_reg;
    logic              out_stat_reg;
    logic              out_valid_reg;

    // lattice memories
    bop_pkg::price_t   price_mem [0:MAX_STEPS];
    bop_pkg::price_t   value_mem [0:MAX_STEPS];
    bop_pkg::price_t   prd_reg;
    bop_pkg::price_t   vrd_reg;

    logic [AW-1:0]     price_raddr;
    logic [AW-1:0]     value_raddr;
    logic              price_we;
    logic [AW-1:0]     price_waddr;
    bop_pkg::price_t   price_wdata;
    logic              value_we;
    bop_pkg::price_t   value_wdata;

    // shared multiplier
    logic              fm_start;
    bop_pkg::price_t   fm_x;
    bop_pkg::factor_t  fm_f;
    logic              fm_done;
    bop_pkg::price_t   fm_res;

    // accept-time decisions
    logic              accept;
    logic              prob_ok;
    bop_pkg::factor_t  num;
    bop_pkg::factor_t  den;
    logic [AW-1:0]     n_clamped;

    // divider step
    logic [FW:0]       trial;
    logic              trial_ge;
    bop_pkg::factor_t  rem_next;
    bop_pkg::factor_t  quo_next;

    bop_pkg::price_t   sum_ab;
    bop_pkg::price_t   node_val;

    function automatic bop_pkg::price_t payoff(input bop_pkg::price_t price,
                                               input bop_pkg::price_t strike,
                                               input logic put);
        bop_pkg::price_t r;
        r = '0;
        if (put && strike > price)
            r = strike - price;
        else if (!put && price > strike)
            r = price - strike;
        return r;
    endfunction

    assign accept = request.valid && request.ready;

    // risk-neutral probability check, either order of up and down
    always_comb
    begin
        if (up_reg > down_reg)
        begin
            prob_ok = (growth_reg >= down_reg) && (growth_reg <= up_reg);
            num     = growth_reg - down_reg;
            den     = up_reg - down_reg;
        end
        else if (up_reg < down_reg)
        begin
            prob_ok = (growth_reg >= up_reg) && (growth_reg <= down_reg);
            num     = down_reg - growth_reg;
            den     = down_reg - up_reg;
        end
        else
        begin
            prob_ok = 1'b0;
            num     = '0;
            den     = bop_pkg::factor_t'(1);
        end
    end

    // zero steps acts as one, too many clamps to the built depth
    always_comb
    begin
        if (steps_reg == '0)
            n_clamped = AW'(1);
        else if (32'(steps_reg) > 32'(MAX_STEPS))
            n_clamped = N_MAX;
        else
            n_clamped = AW'(steps_reg);
    end

    // restoring division, one quotient bit a cycle
    assign trial    = {rem_reg, divd_reg[DW-1]};
    assign trial_ge = trial >= {1'b0, den_reg};
    assign rem_next = trial_ge ? FW'(trial - {1'b0, den_reg}) : trial[FW-1:0];
    assign quo_next = {quo_reg[FW-2:0], trial_ge};

    // saturating sum of the two weighted successors
    always_comb
    begin
        if (a_reg > ('1 - fm_res))
            sum_ab = '1;
        else
            sum_ab = a_reg + fm_res;
    end

    // continuation against early exercise (ex_reg is zero for european)
    assign node_val = (ex_reg > cont_reg) ? ex_reg : cont_reg;

    // multiplier operand selection
    always_comb
    begin
        fm_start = 1'b0;
        fm_x     = '0;
        fm_f     = '0;
        unique case (state_reg)
            ST_FU_GO:
            begin
                fm_start = 1'b1;
                fm_x     = prd_reg;
                fm_f     = up_reg;
            end
            ST_FD_GO:
            begin
                fm_start = 1'b1;
                fm_x     = prd_reg;
                fm_f     = down_reg;
            end
            ST_B_M1:
            begin
                fm_start = 1'b1;
                fm_x     = vrd_reg;
                fm_f     = p_reg;
            end
            ST_B_M2:
            begin
                fm_start = 1'b1;
                fm_x     = carry_reg;
                fm_f     = qp_reg;
            end
            ST_B_M3:
            begin
                fm_start = 1'b1;
                fm_x     = s_reg;
                fm_f     = disc_reg;
            end
            ST_B_M4:
            begin
                fm_start = 1'b1;
                fm_x     = phold_reg;
                fm_f     = up_reg;
            end
            default:
            begin
                fm_start = 1'b0;
            end
        endcase
    end

    bop_fmul u_fmul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (fm_start),
        .x       (fm_x),
        .f       (fm_f),
        .done    (fm_done),
        .product (fm_res)
    );

    // memory addressing
    assign price_raddr = (state_reg == ST_FU_RD) ? i_reg : j_reg;
    assign value_raddr = (state_reg == ST_B_LD) ? '0 : AW'(j_reg + AW'(1));

    always_comb
    begin
        price_we    = 1'b0;
        price_waddr = j_reg;
        price_wdata = fm_res;
        value_we    = 1'b0;
        value_wdata = node_val;
        unique case (state_reg)
            ST_F_INIT:
            begin
                price_we    = 1'b1;
                price_waddr = '0;
                price_wdata = spot_reg;
            end
            ST_FU_WT:
            begin
                price_we    = fm_done;
                price_waddr = AW'(i_reg + AW'(1));
            end
            ST_FD_WT, ST_B_W4:
            begin
                price_we    = fm_done;
            end
            ST_L_WR:
            begin
                value_we    = 1'b1;
                value_wdata = payoff(prd_reg, strike_reg, put_reg);
            end
            ST_B_WR:
            begin
                value_we    = 1'b1;
            end
            default:
            begin
                price_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (price_we)
            price_mem[price_waddr] <= price_wdata;
        prd_reg <= price_mem[price_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (value_we)
            value_mem[j_reg] <= value_wdata;
        vrd_reg <= value_mem[value_raddr];
    end

    // configuration writes, read by the sequencer while an item is priced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg     <= bop_pkg::ONE_Q30;
            down_reg   <= bop_pkg::ONE_Q30;
            growth_reg <= bop_pkg::ONE_Q30;
            disc_reg   <= bop_pkg::ONE_Q30;
            steps_reg  <= bop_pkg::STEPS_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bop_pkg::CFG_UP:       up_reg     <= cfg_data;
                bop_pkg::CFG_DOWN:     down_reg   <= cfg_data;
                bop_pkg::CFG_GROWTH:   growth_reg <= cfg_data;
                bop_pkg::CFG_DISCOUNT: disc_reg   <= cfg_data;
                bop_pkg::CFG_STEPS:    steps_reg  <= cfg_data[bop_pkg::STEPS_WIDTH-1:0];
                default:               ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            spot_reg      <= '0;
            strike_reg    <= '0;
            put_reg       <= 1'b0;
            amer_reg      <= 1'b0;
            den_reg       <= '0;
            rem_reg       <= '0;
            divd_reg      <= '0;
            quo_reg       <= '0;
            dcnt_reg      <= '0;
            p_reg         <= '0;
            qp_reg        <= '0;
            carry_reg     <= '0;
            vnext_reg     <= '0;
            phold_reg     <= '0;
            a_reg         <= '0;
            s_reg         <= '0;
            cont_reg      <= '0;
            ex_reg        <= '0;
            fin_val_reg   <= '0;
            fin_stat_reg  <= 1'b0;
            out_val_reg   <= '0;
            out_stat_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        spot_reg   <= request.spot_price;
                        strike_reg <= request.strike_price;
                        put_reg    <= request.is_put;
                        amer_reg   <= request.early_exercise;
                        n_reg      <= n_clamped;
                        den_reg    <= den;
                        rem_reg    <= '0;
                        divd_reg   <= {num, FB'(0)};
                        quo_reg    <= '0;
                        dcnt_reg   <= '0;
                        if (prob_ok)
                            state_reg <= ST_DIV;
                        else
                        begin
                            fin_val_reg  <= '0;
                            fin_stat_reg <= 1'b1;
                            state_reg    <= ST_DONE;
                        end
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_next;
                    quo_reg  <= quo_next;
                    divd_reg <= {divd_reg[DW-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg + CW'(1);
                    if (dcnt_reg == DIV_LAST)
                    begin
                        p_reg     <= quo_next;
                        qp_reg    <= bop_pkg::ONE_Q30 - quo_next;
                        i_reg     <= '0;
                        state_reg <= ST_F_INIT;
                    end
                end
                // forward build of the price triangle
                ST_F_INIT: state_reg <= ST_FU_RD;
                ST_FU_RD:  state_reg <= ST_FU_GO;
                ST_FU_GO:  state_reg <= ST_FU_WT;
                ST_FU_WT:
                begin
                    if (fm_done)
                    begin
                        j_reg     <= '0;
                        state_reg <= ST_FD_RD;
                    end
                end
                ST_FD_RD:  state_reg <= ST_FD_GO;
                ST_FD_GO:  state_reg <= ST_FD_WT;
                ST_FD_WT:
                begin
                    if (fm_done)
                    begin
                        if (j_reg != i_reg)
                        begin
                            j_reg     <= j_reg + AW'(1);
                            state_reg <= ST_FD_RD;
                        end
                        else if (i_reg == AW'(n_reg - AW'(1)))
                        begin
                            j_reg     <= '0;
                            state_reg <= ST_L_RD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + AW'(1);
                            state_reg <= ST_FU_RD;
                        end
                    end
                end
                // leaf payoffs
                ST_L_RD:   state_reg <= ST_L_WR;
                ST_L_WR:
                begin
                    if (j_reg == n_reg)
                    begin
                        i_reg     <= AW'(n_reg - AW'(1));
                        j_reg     <= '0;
                        state_reg <= ST_B_LD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + AW'(1);
                        state_reg <= ST_L_RD;
                    end
                end
                // backward induction, i_reg holds the level
                ST_B_LD:   state_reg <= ST_B_LD0;
                ST_B_LD0:
                begin
                    carry_reg <= vrd_reg;
                    state_reg <= ST_B_RD;
                end
                ST_B_RD:   state_reg <= ST_B_M1;
                ST_B_M1:
                begin
                    vnext_reg <= vrd_reg;
                    phold_reg <= prd_reg;
                    state_reg <= ST_B_W1;
                end
                ST_B_W1:
                begin
                    if (fm_done)
                    begin
                        a_reg     <= fm_res;
                        state_reg <= ST_B_M2;
                    end
                end
                ST_B_M2:   state_reg <= ST_B_W2;
                ST_B_W2:
                begin
                    if (fm_done)
                    begin
                        s_reg     <= sum_ab;
                        state_reg <= ST_B_M3;
                    end
                end
                ST_B_M3:   state_reg <= ST_B_W3;
                ST_B_W3:
                begin
                    if (fm_done)
                    begin
                        cont_reg  <= fm_res;
                        ex_reg    <= '0;
                        state_reg <= amer_reg ? ST_B_M4 : ST_B_WR;
                    end
                end
                ST_B_M4:   state_reg <= ST_B_W4;
                ST_B_W4:
                begin
                    if (fm_done)
                    begin
                        ex_reg    <= payoff(fm_res, strike_reg, put_reg);
                        state_reg <= ST_B_WR;
                    end
                end
                ST_B_WR:
                begin
                    carry_reg <= vnext_reg;
                    if (j_reg != i_reg)
                    begin
                        j_reg     <= j_reg + AW'(1);
                        state_reg <= ST_B_RD;
                    end
                    else if (i_reg == '0)
                    begin
                        fin_val_reg  <= node_val;
                        fin_stat_reg <= 1'b0;
                        state_reg    <= ST_DONE;
                    end
                    else
                    begin
                        i_reg     <= i_reg - AW'(1);
                        j_reg     <= '0;
                        state_reg <= ST_B_LD;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_val_reg   <= fin_val_reg;
                        out_stat_reg  <= fin_stat_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign request.ready       = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.option_value = out_val_reg;
    assign result.status       = out_stat_reg;

    // a rejected item always reports a zero value
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status |-> result.option_value == '0)
        else $error("status set with nonzero option value");

    // one item at a time: no second accept right after the first
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !request.ready)
        else $error("request taken while an item is in flight");

    // multiplier answers only where the sequencer waits for it
    a_fmul_owner: assert property (@(posedge clk) disable iff (!rst_n)
        fm_done |-> (state_reg == ST_FU_WT || state_reg == ST_FD_WT ||
                     state_reg == ST_B_W1 || state_reg == ST_B_W2 ||
                     state_reg == ST_B_W3 || state_reg == ST_B_W4))
        else $error("multiplier result with no waiting state");

    // up probability never exceeds one
    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg <= bop_pkg::ONE_Q30)
        else $error("up probability above one");

endmodule
